// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gmr_pkg.sv =====
package gmr_pkg;

    localparam int RUN_W      = 10;
    localparam int PERIOD_W   = 8;
    localparam int DEB_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TICK_W     = 4;
    localparam int IN_TW      = 8;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_CLOSE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        LIM_NONE  = 2'd0,
        LIM_LEFT  = 2'd1,
        LIM_RIGHT = 2'd2
    } t_limit;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd3;

    localparam logic [RUN_W-1:0]    RST_RUN_SPEED   = 10'd1000;
    localparam logic [PERIOD_W-1:0] RST_UP_PERIOD   = 8'd5;
    localparam logic [PERIOD_W-1:0] RST_DOWN_PERIOD = 8'd4;
    localparam logic [DEB_W-1:0]    RST_DEBOUNCE    = 10'd200;

    // one tick sample, open_b in bit 0
    typedef struct packed {
        logic right;
        logic left;
        logic close_b;
        logic open_b;
    } t_tick;

    // switch/button stage result handed to the ramp stage
    typedef struct packed {
        t_mode  mode;
        t_limit limit;
        logic   stopped;
    } t_ctl;

endpackage

// ===== rtl/gmr_ctrl.sv =====
module gmr_ctrl (
    input  gmr_pkg::t_tick              i_tick,
    input  logic                        i_prev_left,
    input  logic                        i_prev_right,
    input  gmr_pkg::t_mode              i_mode,
    input  gmr_pkg::t_limit             i_limit,
    input  logic [gmr_pkg::DEB_W-1:0]   i_debounce_count,
    input  logic [gmr_pkg::DEB_W-1:0]   i_debounce_ticks,
    output gmr_pkg::t_ctl               o_ctl,
    output logic [gmr_pkg::DEB_W-1:0]   o_debounce_count
);
    import gmr_pkg::*;

    t_limit lim_l;
    t_limit lim_r;
    logic   stop_l;
    logic   stop_r;
    t_mode  mode_n;

    // end switch edges, right evaluated after left
    always_comb begin
        lim_l  = i_limit;
        stop_l = 1'b0;
        if (i_tick.left && !i_prev_left) begin
            lim_l  = LIM_LEFT;
            stop_l = 1'b1;
        end else if (!i_tick.left && i_prev_left && i_limit == LIM_LEFT) begin
            lim_l = LIM_NONE;
        end

        lim_r  = lim_l;
        stop_r = stop_l;
        if (i_tick.right && !i_prev_right) begin
            lim_r  = LIM_RIGHT;
            stop_r = 1'b1;
        end else if (!i_tick.right && i_prev_right && lim_l == LIM_RIGHT) begin
            lim_r = LIM_NONE;
        end
    end

    // buttons, open wins a tie
    always_comb begin
        mode_n           = i_mode;
        o_debounce_count = i_debounce_count;
        if (i_debounce_count != '0) begin
            o_debounce_count = i_debounce_count - 1'b1;
        end else if (i_tick.open_b) begin
            mode_n           = (i_mode == MODE_OPEN) ? MODE_IDLE : MODE_OPEN;
            o_debounce_count = i_debounce_ticks;
        end else if (i_tick.close_b) begin
            mode_n           = (i_mode == MODE_CLOSE) ? MODE_IDLE : MODE_CLOSE;
            o_debounce_count = i_debounce_ticks;
        end
    end

    assign o_ctl.mode    = mode_n;
    assign o_ctl.limit   = lim_r;
    assign o_ctl.stopped = stop_r;

endmodule

// ===== rtl/gmr_ramp.sv =====
module gmr_ramp #(
    parameter int SPEED_BITS = 10
) (
    input  gmr_pkg::t_ctl                    i_ctl,
    input  logic signed [SPEED_BITS:0]       i_speed,
    input  logic                             i_direction,
    input  logic [gmr_pkg::PERIOD_W-1:0]     i_ramp_count,
    input  logic [gmr_pkg::RUN_W-1:0]        i_run_speed,
    input  logic [gmr_pkg::PERIOD_W-1:0]     i_up_period,
    input  logic [gmr_pkg::PERIOD_W-1:0]     i_down_period,
    output logic signed [SPEED_BITS:0]       o_speed,
    output logic                             o_direction,
    output logic [gmr_pkg::PERIOD_W-1:0]     o_ramp_count
);
    import gmr_pkg::*;

    localparam int SW = SPEED_BITS + 1;
    localparam int MW = (SPEED_BITS > RUN_W) ? SPEED_BITS : RUN_W;
    localparam logic [MW-1:0] SPEED_MAX_M = MW'((64'd1 << SPEED_BITS) - 64'd1);

    logic [MW-1:0]           run_ext;
    logic [SPEED_BITS-1:0]   mag;
    logic signed [SW-1:0]    target;
    logic [PERIOD_W-1:0]     period_raw;
    logic [PERIOD_W-1:0]     period;
    logic [PERIOD_W:0]       count_inc;
    logic                    blocked;
    logic signed [SW-1:0]    stepped;

    assign run_ext = MW'(i_run_speed);
    assign mag     = (run_ext > SPEED_MAX_M) ? SPEED_MAX_M[SPEED_BITS-1:0]
                                             : run_ext[SPEED_BITS-1:0];

    always_comb begin
        case (i_ctl.mode)
            MODE_OPEN:  target = $signed({1'b0, mag});
            MODE_CLOSE: target = -$signed({1'b0, mag});
            default:    target = '0;
        endcase
    end

    assign blocked = (i_ctl.mode == MODE_OPEN  && i_ctl.limit == LIM_LEFT) ||
                     (i_ctl.mode == MODE_CLOSE && i_ctl.limit == LIM_RIGHT);

    assign period_raw = (i_ctl.mode == MODE_OPEN || i_ctl.mode == MODE_CLOSE) ?
                        i_up_period : i_down_period;
    // zero period steps every tick
    assign period    = (period_raw == '0) ? PERIOD_W'(1) : period_raw;
    assign count_inc = {1'b0, i_ramp_count} + (PERIOD_W+1)'(1);
    assign stepped   = (i_speed < target) ? i_speed + SW'(1) : i_speed - SW'(1);

    always_comb begin
        o_speed      = i_speed;
        o_direction  = i_direction;
        o_ramp_count = '0;
        if (i_ctl.stopped) begin
            o_speed = '0;
        end else begin
            if (!blocked && i_speed != target) begin
                if (count_inc >= {1'b0, period}) begin
                    o_speed = stepped;
                    if (i_ctl.mode != MODE_IDLE && (i_speed == '0 || stepped == '0)) begin
                        o_direction = target[SW-1];
                    end
                end else begin
                    o_ramp_count = count_inc[PERIOD_W-1:0];
                end
            end
            if (i_ctl.mode != MODE_OPEN && i_ctl.mode != MODE_CLOSE && o_speed == '0) begin
                o_direction = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/gate_motor_ramp_controller.sv =====
// Gate motor soft-start ramp controller with end switches.
//
// Input stream: one transaction per 1 ms tick, tdata carries the sampled
// buttons and end switches. Output stream: one transaction per tick with
// the duty, direction pin, signed speed, mode and limit state after it.
// Config channel: register index and data, always ready; write only while
// no tick is in flight.
//
// Timing: the result appears in the output register in the cycle after the
// input transaction. Throughput: one tick per cycle while the receiver takes
// results; all the per-tick work (edge detect, debounce, one ramp step) sits
// between the state registers and the output register.
//
// Reset (synchronous, active low): mode idle, speed zero, counters cleared,
// config registers at their defaults, no result pending.
// Receiver stall: the output register holds its transaction, s_axis tready
// drops until it is taken, and the state advances only on accepted ticks.
module gate_motor_ramp_controller #(
    parameter int SPEED_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave side: [0] open_button [1] close_button [2] left_switch
    // [3] right_switch, rest zero
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [gmr_pkg::IN_TW-1:0]              i_s_axis_tdata,
    // master side, low bits up: pwm_duty, direction, speed, mode,
    // limit_state, zero fill to whole bytes
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [((2*SPEED_BITS+6+7)/8)*8-1:0]    o_m_axis_tdata,
    // config write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [gmr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [gmr_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import gmr_pkg::*;

    localparam int SW     = SPEED_BITS + 1;
    localparam int OUT_W  = 2 * SPEED_BITS + 6;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    // config registers
    logic [RUN_W-1:0]    r_run_speed;
    logic [PERIOD_W-1:0] r_up_period;
    logic [PERIOD_W-1:0] r_down_period;
    logic [DEB_W-1:0]    r_debounce_ticks;

    // tick state
    t_mode               r_mode;
    t_limit              r_limit;
    logic signed [SW-1:0] r_speed;
    logic                r_direction;
    logic                r_prev_left;
    logic                r_prev_right;
    logic [PERIOD_W-1:0] r_ramp_count;
    logic [DEB_W-1:0]    r_debounce_count;

    // output register
    logic                r_out_valid;
    logic [OUT_TW-1:0]   r_out_data;

    t_tick               tick;
    t_ctl                ctl;
    logic [DEB_W-1:0]    n_debounce_count;
    logic signed [SW-1:0] n_speed;
    logic                n_direction;
    logic [PERIOD_W-1:0] n_ramp_count;
    logic [SW-1:0]       n_abs;
    logic                s_accept;

    assign tick            = t_tick'(i_s_axis_tdata[TICK_W-1:0]);
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    gmr_ctrl u_ctrl (
        .i_tick           (tick),
        .i_prev_left      (r_prev_left),
        .i_prev_right     (r_prev_right),
        .i_mode           (r_mode),
        .i_limit          (r_limit),
        .i_debounce_count (r_debounce_count),
        .i_debounce_ticks (r_debounce_ticks),
        .o_ctl            (ctl),
        .o_debounce_count (n_debounce_count)
    );

    gmr_ramp #(
        .SPEED_BITS (SPEED_BITS)
    ) u_ramp (
        .i_ctl         (ctl),
        .i_speed       (r_speed),
        .i_direction   (r_direction),
        .i_ramp_count  (r_ramp_count),
        .i_run_speed   (r_run_speed),
        .i_up_period   (r_up_period),
        .i_down_period (r_down_period),
        .o_speed       (n_speed),
        .o_direction   (n_direction),
        .o_ramp_count  (n_ramp_count)
    );

    // duty is the magnitude; speed never reaches the most negative code
    assign n_abs = n_speed[SW-1] ? SW'(-n_speed) : SW'(n_speed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_speed      <= RST_RUN_SPEED;
            r_up_period      <= RST_UP_PERIOD;
            r_down_period    <= RST_DOWN_PERIOD;
            r_debounce_ticks <= RST_DEBOUNCE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RUN_SPEED:   r_run_speed      <= i_cfg_data[RUN_W-1:0];
                CFG_UP_PERIOD:   r_up_period      <= i_cfg_data[PERIOD_W-1:0];
                CFG_DOWN_PERIOD: r_down_period    <= i_cfg_data[PERIOD_W-1:0];
                CFG_DEBOUNCE:    r_debounce_ticks <= i_cfg_data[DEB_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_IDLE;
            r_limit          <= LIM_NONE;
            r_speed          <= '0;
            r_direction      <= 1'b0;
            r_prev_left      <= 1'b0;
            r_prev_right     <= 1'b0;
            r_ramp_count     <= '0;
            r_debounce_count <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (s_accept) begin
                r_mode           <= ctl.mode;
                r_limit          <= ctl.limit;
                r_speed          <= n_speed;
                r_direction      <= n_direction;
                r_prev_left      <= tick.left;
                r_prev_right     <= tick.right;
                r_ramp_count     <= n_ramp_count;
                r_debounce_count <= n_debounce_count;
                r_out_valid      <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= OUT_TW'({ctl.limit, ctl.mode, n_speed, n_direction,
                                   n_abs[SPEED_BITS-1:0]});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/gmr_checker.sv =====
`include "assert_macros.svh"

module gmr_checker #(
    parameter int SPEED_BITS = 10
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [((2*SPEED_BITS+6+7)/8)*8-1:0]   o_m_axis_tdata
);
    localparam int SW = SPEED_BITS + 1;

    logic [SPEED_BITS-1:0]  c_duty;
    logic                   c_dir;
    logic signed [SW-1:0]   c_speed;
    logic [SW-1:0]          c_abs;

    assign c_duty  = o_m_axis_tdata[SPEED_BITS-1:0];
    assign c_dir   = o_m_axis_tdata[SPEED_BITS];
    assign c_speed = $signed(o_m_axis_tdata[2*SPEED_BITS+1:SPEED_BITS+1]);
    assign c_abs   = c_speed[SW-1] ? SW'(-c_speed) : SW'(c_speed);

    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, o_m_axis_tvalid, "tick accepted but no result")
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty output")
    `ASSERT_IMPL(a_duty_magnitude, i_clk, i_rst_n, o_m_axis_tvalid, {1'b0, c_duty} == c_abs, "duty differs from speed magnitude")
    `ASSERT_IMPL(a_dir_sign, i_clk, i_rst_n, o_m_axis_tvalid && c_speed != '0, c_dir == c_speed[SW-1], "direction pin disagrees with speed sign")

endmodule

bind gate_motor_ramp_controller gmr_checker #(.SPEED_BITS(SPEED_BITS)) u_gmr_checker (.*);

// ===== dv/tb.sv =====
module tb;
    import gmr_pkg::*;

    localparam int SPEED_BITS  = 10;
    localparam int OUT_W       = ((2*SPEED_BITS+6+7)/8)*8;
    localparam int CYCLE_LIMIT = 300000;

    // output transaction layout, lowest field last
    typedef struct packed {
        logic [OUT_W-(2*SPEED_BITS+6)-1:0] pad;
        t_limit                            limit;
        t_mode                             mode;
        logic signed [SPEED_BITS:0]        speed;
        logic                              dir;
        logic [SPEED_BITS-1:0]             duty;
    } t_motor_out;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TW-1:0]        i_s_axis_tdata  = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]        o_m_axis_tdata;
    logic                    i_cfg_valid     = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index     = CFG_RUN_SPEED;
    logic [CFG_DATA_W-1:0]   i_cfg_data      = '0;

    gate_motor_ramp_controller #(.SPEED_BITS(SPEED_BITS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Gate state mirror: config shadow plus the per-tick control state
    // ------------------------------------------------------------------
    logic [RUN_W-1:0]        cfg_run      = RST_RUN_SPEED;
    logic [PERIOD_W-1:0]     cfg_up       = RST_UP_PERIOD;
    logic [PERIOD_W-1:0]     cfg_down     = RST_DOWN_PERIOD;
    logic [DEB_W-1:0]        cfg_debounce = RST_DEBOUNCE;

    t_mode                   gate_mode    = MODE_IDLE;
    t_limit                  gate_limit   = LIM_NONE;
    logic signed [SPEED_BITS:0] motor_speed = '0;
    logic                    motor_dir    = 1'b0;
    logic                    last_left    = 1'b0;
    logic                    last_right   = 1'b0;
    logic [PERIOD_W-1:0]     ramp_cnt     = '0;
    logic [DEB_W-1:0]        deb_cnt      = '0;

    // One tick: switch edges first, then buttons, then at most one ramp step.
    function automatic t_motor_out advance_gate(t_tick tk);
        t_motor_out r;
        logic       stopped;
        logic       blocked;
        int         target;
        int         period;
        int         old_speed;
        stopped = 1'b0;
        if (tk.left && !last_left) begin
            gate_limit  = LIM_LEFT;
            motor_speed = '0;
            stopped     = 1'b1;
        end else if (!tk.left && last_left && gate_limit == LIM_LEFT) begin
            gate_limit = LIM_NONE;
        end
        // right is evaluated last, so it wins a simultaneous edge
        if (tk.right && !last_right) begin
            gate_limit  = LIM_RIGHT;
            motor_speed = '0;
            stopped     = 1'b1;
        end else if (!tk.right && last_right && gate_limit == LIM_RIGHT) begin
            gate_limit = LIM_NONE;
        end
        last_left  = tk.left;
        last_right = tk.right;

        if (deb_cnt != 0) begin
            deb_cnt = deb_cnt - 1'b1;
        end else if (tk.open_b) begin
            gate_mode = (gate_mode == MODE_OPEN) ? MODE_IDLE : MODE_OPEN;
            deb_cnt   = cfg_debounce;
        end else if (tk.close_b) begin
            gate_mode = (gate_mode == MODE_CLOSE) ? MODE_IDLE : MODE_CLOSE;
            deb_cnt   = cfg_debounce;
        end

        if (stopped) begin
            ramp_cnt = '0;
        end else begin
            // run_speed is 10 bits, never above the speed range here
            if (gate_mode == MODE_OPEN)
                target = int'(cfg_run);
            else if (gate_mode == MODE_CLOSE)
                target = -int'(cfg_run);
            else
                target = 0;
            blocked = (gate_mode == MODE_OPEN  && gate_limit == LIM_LEFT) ||
                      (gate_mode == MODE_CLOSE && gate_limit == LIM_RIGHT);
            period  = (gate_mode == MODE_IDLE) ? int'(cfg_down) : int'(cfg_up);
            if (period == 0)
                period = 1;
            if (blocked || int'(motor_speed) == target) begin
                ramp_cnt = '0;
            end else begin
                ramp_cnt = ramp_cnt + 1'b1;
                if (int'(ramp_cnt) >= period) begin
                    old_speed   = int'(motor_speed);
                    ramp_cnt    = '0;
                    motor_speed = (SPEED_BITS+1)'(old_speed +
                                                  ((old_speed < target) ? 1 : -1));
                    // direction pin only moves at the zero crossing
                    if (gate_mode != MODE_IDLE && (old_speed == 0 || motor_speed == 0))
                        motor_dir = (target < 0);
                end
            end
            if (gate_mode == MODE_IDLE && motor_speed == 0)
                motor_dir = 1'b0;
        end

        r       = '0;
        r.duty  = SPEED_BITS'((motor_speed < 0) ? -motor_speed : motor_speed);
        r.dir   = motor_dir;
        r.speed = motor_speed;
        r.mode  = gate_mode;
        r.limit = gate_limit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_tick      tick_pending_q[$];   // ticks waiting for the driver
    t_motor_out motor_expected_q[$]; // predicted outputs, oldest first

    int  ticks_queued    = 0;
    int  ticks_taken     = 0;
    int  results_checked = 0;
    int  cfg_writes      = 0;
    int  fail_cnt        = 0;
    int  cycle_cnt       = 0;

    logic tick_fire = 1'b0;  // input transaction at the last rising edge
    logic res_fire  = 1'b0;  // output transaction at the last rising edge

    int  tick_gap  = 0;
    int  res_stall = 0;
    bit  tick_calm = 1'b0;
    bit  res_calm  = 1'b0;

    // switch levels for the random part; they mostly hold and flip rarely
    logic sw_left  = 1'b0;
    logic sw_right = 1'b0;

    // Per-transaction random wait, with runs of back-to-back traffic.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 19) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic t_tick random_tick();
        t_tick tk;
        int    roll;
        roll = $urandom_range(0, 39);
        // mostly idle ticks, occasional single presses, rare double press
        tk.open_b  = (roll < 3) || (roll == 39);
        tk.close_b = (roll >= 3 && roll < 6) || (roll == 39);
        if ($urandom_range(0, 24) == 0)
            sw_left = !sw_left;
        if ($urandom_range(0, 24) == 0)
            sw_right = !sw_right;
        tk.left  = sw_left;
        tk.right = sw_right;
        return tk;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: changes at the falling edge, one transaction per item
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic             v;
        logic [IN_TW-1:0] d;
        v = i_s_axis_tvalid;
        d = i_s_axis_tdata;
        if (i_rst_n) begin
            if (v && tick_fire)
                v = 1'b0;
            if (!v) begin
                if (tick_gap != 0) begin
                    tick_gap = tick_gap - 1;
                end else if (tick_pending_q.size() != 0) begin
                    d        = {{(IN_TW-4){1'b0}}, tick_pending_q.pop_front()};
                    v        = 1'b1;
                    tick_gap = draw_wait(tick_calm);
                end
            end
        end
        i_s_axis_tvalid <= v;
        i_s_axis_tdata  <= d;
    end

    // Output side back-pressure: after each taken transaction, stall a while.
    always @(negedge i_clk) begin
        logic r;
        r = i_m_axis_tready;
        if (i_rst_n) begin
            if (r && res_fire)
                res_stall = draw_wait(res_calm);
            if (res_stall != 0) begin
                r         = 1'b0;
                res_stall = res_stall - 1;
            end else begin
                r = 1'b1;
            end
        end
        i_m_axis_tready <= r;
    end

    // ------------------------------------------------------------------
    // Monitor: checks results first, then folds in config and new ticks
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_motor_out got;
        t_motor_out want;
        logic       tf;
        logic       rf;
        tf = 1'b0;
        rf = 1'b0;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                rf  = 1'b1;
                got = t_motor_out'(o_m_axis_tdata);
                results_checked = results_checked + 1;
                if (motor_expected_q.size() == 0) begin
                    $display("%0t unexpected result transaction, got %h",
                             $time, o_m_axis_tdata);
                    fail_cnt = fail_cnt + 1;
                end else begin
                    want = motor_expected_q.pop_front();
                    if (got.duty !== want.duty) begin
                        $display("%0t pwm_duty expected %0d actual %0d",
                                 $time, want.duty, got.duty);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (got.dir !== want.dir) begin
                        $display("%0t direction expected %0d actual %0d",
                                 $time, want.dir, got.dir);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (got.speed !== want.speed) begin
                        $display("%0t speed expected %0d actual %0d",
                                 $time, want.speed, got.speed);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (got.mode !== want.mode) begin
                        $display("%0t mode expected %0d actual %0d",
                                 $time, want.mode, got.mode);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (got.limit !== want.limit) begin
                        $display("%0t limit_state expected %0d actual %0d",
                                 $time, want.limit, got.limit);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RUN_SPEED:   cfg_run      = i_cfg_data[RUN_W-1:0];
                    CFG_UP_PERIOD:   cfg_up       = i_cfg_data[PERIOD_W-1:0];
                    CFG_DOWN_PERIOD: cfg_down     = i_cfg_data[PERIOD_W-1:0];
                    CFG_DEBOUNCE:    cfg_debounce = i_cfg_data[DEB_W-1:0];
                    default: ;
                endcase
                cfg_writes = cfg_writes + 1;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                tf = 1'b1;
                motor_expected_q.push_back(advance_gate(t_tick'(i_s_axis_tdata[3:0])));
                ticks_taken = ticks_taken + 1;
            end
        end
        tick_fire <= tf;
        res_fire  <= rf;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int done_at;
        done_at = cfg_writes + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        wait (cfg_writes == done_at);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Block is idle once every queued tick has been taken and answered.
    task settle();
        wait (ticks_taken == ticks_queued && results_checked == ticks_taken);
        repeat (2) @(negedge i_clk);
    endtask

    task push_tick(input int o, input int c, input int l, input int r);
        t_tick tk;
        tk.open_b  = 1'(o);
        tk.close_b = 1'(c);
        tk.left    = 1'(l);
        tk.right   = 1'(r);
        tick_pending_q.push_back(tk);
        ticks_queued = ticks_queued + 1;
    endtask

    task run_phase(input int run, input int up, input int down, input int deb,
                   input int n_ticks);
        settle();
        write_reg(CFG_RUN_SPEED,   CFG_DATA_W'(run));
        write_reg(CFG_UP_PERIOD,   CFG_DATA_W'(up));
        write_reg(CFG_DOWN_PERIOD, CFG_DATA_W'(down));
        write_reg(CFG_DEBOUNCE,    CFG_DATA_W'(deb));
        repeat (n_ticks) begin
            tick_pending_q.push_back(random_tick());
            ticks_queued = ticks_queued + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: short ramps so every case shows within a few ticks
        write_reg(CFG_RUN_SPEED,   CFG_DATA_W'(3));
        write_reg(CFG_UP_PERIOD,   CFG_DATA_W'(1));
        write_reg(CFG_DOWN_PERIOD, CFG_DATA_W'(2));
        write_reg(CFG_DEBOUNCE,    CFG_DATA_W'(2));
        push_tick(1, 0, 0, 0);  // open from idle
        push_tick(0, 0, 0, 0);
        push_tick(1, 0, 0, 0);  // inside debounce, ignored
        push_tick(0, 1, 0, 0);  // close while running at speed, crosses zero
        push_tick(0, 0, 0, 0);
        push_tick(0, 0, 0, 0);
        push_tick(0, 0, 0, 0);
        push_tick(1, 1, 0, 0);  // both pressed, open wins
        push_tick(0, 0, 0, 0);
        push_tick(0, 0, 0, 0);
        push_tick(0, 0, 1, 0);  // left hit while opening, hard stop
        push_tick(0, 0, 1, 0);  // opening refused
        push_tick(0, 0, 1, 0);
        push_tick(0, 1, 1, 0);  // close away from left is allowed
        push_tick(0, 0, 1, 0);
        push_tick(0, 0, 0, 0);  // left released
        push_tick(0, 0, 0, 1);  // right hit while closing
        push_tick(0, 0, 0, 1);  // closing refused
        push_tick(0, 1, 0, 0);  // same button again, soft stop to idle
        push_tick(0, 0, 1, 1);  // both switches at once, right wins
        push_tick(0, 0, 1, 0);  // right released, limit clears
        push_tick(0, 0, 1, 1);  // right again
        push_tick(0, 0, 0, 1);  // left released, right stays named
        push_tick(1, 0, 0, 1);
        push_tick(0, 0, 0, 0);

        run_phase(5,    1,   1,   3,    100);
        run_phase(1023, 1,   1,   0,    150);
        run_phase(0,    0,   0,   1023, 80);
        run_phase(40,   255, 255, 10,   100);
        run_phase(20,   2,   3,   5,    100);
        run_phase(1000, 5,   4,   200,  80);

        settle();
        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0 && results_checked == ticks_taken) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
